// File: hw/rtl/assert_macros.svh
// assertion macros used by the fifo page replacement datapath rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds whenever the antecedent holds in the same cycle
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// property holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/fpr_pkg.sv
// shared constants and controller/datapath interface types for the page replacement unit
// no dependencies
`timescale 1ns / 1ps

package fpr_pkg;

  // default sizes
  localparam int unsigned VIRTUAL_PAGES_DEF = 32;
  localparam int unsigned MAX_FRAMES_DEF    = 32;
  localparam int unsigned COUNT_WIDTH_DEF   = 16;

  // fixed port field widths
  localparam int unsigned PAGE_FIELD_W  = 5;
  localparam int unsigned FRAME_FIELD_W = 5;
  localparam int unsigned COUNT_FIELD_W = 16;
  localparam int unsigned CFG_W         = 6;
  localparam int unsigned PAGE_SPAN     = 2 ** PAGE_FIELD_W;

  // frame count after reset
  localparam int unsigned FRAME_COUNT_RESET = 4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic restart;     // config write: reload frame count, clear run state
    logic clr_wr;      // clear one page table entry
    logic accept;      // latch page, read page table and victim owner
    logic decide;      // latch hit, frame and eviction choice
    logic invalidate;  // drop the evicted page from the page table
    logic place;       // map the page to its new frame
    logic load;        // update counters, load output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clr_last;    // clearing pass at its final entry
    logic hit;         // page table read shows the page resident
    logic room;        // a never-used frame is still free
    logic out_free;    // output register can take a result
  } status_t;

endpackage

// File: hw/rtl/fifo_page_replacement_top.sv
// fifo page replacement unit: page table lookup with round robin frame eviction
// usage:
//   input channel carries page_number_i; a transfer happens when in_valid_i is
//   high and in_stall_o is low. output channel carries one result per access
//   (hit, frame, eviction, saturating fault and access totals); a transfer
//   happens when out_valid_o is high and out_stall_i is low.
//   config channel writes frame_count_i when cfg_valid_i and cfg_ready_o are high;
//   it clamps 0 to 1 and large values to MAX_FRAMES and restarts the run.
// sequence: an access is accepted, looked up, then its result registered; a fill
//   miss also maps the page to a free frame, an evicting miss first drops the old
//   page from the table and then maps the page. the next access is taken only
//   after the result is loaded, so accesses do not overlap; the steps follow from
//   the registered page table read and its single write port, which the invalidate and map steps take in turn.
// reset and restart: a clearing pass writes every page table entry, with
//   in_stall_o high; frame count resets to 4.
// stall: a result held by out_stall_i stays stable; the block finishes the
//   current access and waits to load the next result until the register frees.
// depends on fpr_pkg, fpr_ctrl, fpr_datapath and fpr_ram
`timescale 1ns / 1ps

module fifo_page_replacement_top #(
  parameter int unsigned VIRTUAL_PAGES = fpr_pkg::VIRTUAL_PAGES_DEF,
  parameter int unsigned MAX_FRAMES    = fpr_pkg::MAX_FRAMES_DEF,
  parameter int unsigned COUNT_WIDTH   = fpr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [fpr_pkg::PAGE_FIELD_W-1:0]  page_number_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_o,
  output logic [fpr_pkg::FRAME_FIELD_W-1:0] frame_number_o,
  output logic                              evicted_valid_o,
  output logic [fpr_pkg::PAGE_FIELD_W-1:0]  evicted_page_o,
  output logic [fpr_pkg::COUNT_FIELD_W-1:0] fault_total_o,
  output logic [fpr_pkg::COUNT_FIELD_W-1:0] access_total_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fpr_pkg::CFG_W-1:0]         frame_count_i
);

  fpr_pkg::cmd_t    cmd;
  fpr_pkg::status_t status;

  fpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fpr_datapath #(
    .VIRTUAL_PAGES (VIRTUAL_PAGES),
    .MAX_FRAMES    (MAX_FRAMES),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .page_number_i   (page_number_i),
    .frame_count_i   (frame_count_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .hit_o           (hit_o),
    .frame_number_o  (frame_number_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_total_o   (fault_total_o),
    .access_total_o  (access_total_o)
  );

endmodule

// File: hw/rtl/fpr_ram.sv
// generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps

module fpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/fpr_datapath.sv
// datapath: page table and frame owner memories, fill and victim pointers,
// saturating counters and output register; depends on fpr_pkg and fpr_ram
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fpr_datapath #(
  parameter int unsigned VIRTUAL_PAGES = fpr_pkg::VIRTUAL_PAGES_DEF,
  parameter int unsigned MAX_FRAMES    = fpr_pkg::MAX_FRAMES_DEF,
  parameter int unsigned COUNT_WIDTH   = fpr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fpr_pkg::cmd_t                        cmd_i,
  output fpr_pkg::status_t                     status_o,
  input  logic [fpr_pkg::PAGE_FIELD_W-1:0]     page_number_i,
  input  logic [fpr_pkg::CFG_W-1:0]            frame_count_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic                                 hit_o,
  output logic [fpr_pkg::FRAME_FIELD_W-1:0]    frame_number_o,
  output logic                                 evicted_valid_o,
  output logic [fpr_pkg::PAGE_FIELD_W-1:0]     evicted_page_o,
  output logic [fpr_pkg::COUNT_FIELD_W-1:0]    fault_total_o,
  output logic [fpr_pkg::COUNT_FIELD_W-1:0]    access_total_o
);

  localparam int unsigned PW    = $clog2(VIRTUAL_PAGES);
  localparam int unsigned FW    = $clog2(MAX_FRAMES);
  localparam int unsigned NW    = $clog2(MAX_FRAMES + 1);
  localparam int unsigned TW    = FW + 1;
  localparam int unsigned CMPW  = (NW > fpr_pkg::CFG_W) ? NW : fpr_pkg::CFG_W;
  localparam int unsigned FXW   = (FW > fpr_pkg::FRAME_FIELD_W) ? FW : fpr_pkg::FRAME_FIELD_W;
  localparam int unsigned PXW   = (PW > fpr_pkg::PAGE_FIELD_W) ? PW : fpr_pkg::PAGE_FIELD_W;
  localparam int unsigned CXW   = (COUNT_WIDTH > fpr_pkg::COUNT_FIELD_W) ?
                                  COUNT_WIDTH : fpr_pkg::COUNT_FIELD_W;
  localparam int unsigned RST_N = (fpr_pkg::FRAME_COUNT_RESET > MAX_FRAMES) ?
                                  MAX_FRAMES : fpr_pkg::FRAME_COUNT_RESET;

  // page number folded into the table range, one constant per input code
  logic [PW-1:0] page_mod [fpr_pkg::PAGE_SPAN];

  for (genvar i = 0; i < fpr_pkg::PAGE_SPAN; i++) begin : g_page_mod
    localparam int unsigned PM = i % VIRTUAL_PAGES;
    assign page_mod[i] = PW'(PM);
  end

  // run state
  logic [NW-1:0]          n_q, n_d;
  logic [NW-1:0]          filled_q, filled_d;
  logic [FW-1:0]          vp_q, vp_d;
  logic [PW-1:0]          clr_addr_q, clr_addr_d;
  logic [COUNT_WIDTH-1:0] fault_q, fault_d;
  logic [COUNT_WIDTH-1:0] acc_q, acc_d;
  logic                   out_valid_q, out_valid_d;

  // per access payload
  logic [PW-1:0] page_q;
  logic          hit_q;
  logic          evict_q;
  logic [FW-1:0] frame_q;
  logic [PW-1:0] old_q;

  // output register
  logic                                 hit_out_q;
  logic [fpr_pkg::FRAME_FIELD_W-1:0]    frame_out_q;
  logic                                 ev_valid_out_q;
  logic [fpr_pkg::PAGE_FIELD_W-1:0]     ev_page_out_q;
  logic [fpr_pkg::COUNT_FIELD_W-1:0]    fault_out_q;
  logic [fpr_pkg::COUNT_FIELD_W-1:0]    acc_out_q;

  // memory ports
  logic          pt_we;
  logic [PW-1:0] pt_waddr;
  logic [TW-1:0] pt_wdata;
  logic [TW-1:0] pt_rdata;
  logic [PW-1:0] own_rdata;

  // clamped frame count from a config write
  logic [CMPW-1:0] fc_ext;
  logic [NW-1:0]   n_cfg;

  assign fc_ext = CMPW'(frame_count_i);

  always_comb begin
    if (fc_ext == '0) begin
      n_cfg = NW'(1);
    end else if (fc_ext > CMPW'(MAX_FRAMES)) begin
      n_cfg = NW'(MAX_FRAMES);
    end else begin
      n_cfg = NW'(fc_ext);
    end
  end

  // status to the controller
  assign status_o.clr_last = (clr_addr_q == PW'(VIRTUAL_PAGES - 1));
  assign status_o.hit      = pt_rdata[FW];
  assign status_o.room     = (filled_q < n_q);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // page table write selection
  always_comb begin
    pt_we    = cmd_i.clr_wr || cmd_i.invalidate || cmd_i.place;
    pt_waddr = clr_addr_q;
    pt_wdata = '0;
    priority if (cmd_i.place) begin
      pt_waddr = page_q;
      pt_wdata = {1'b1, frame_q};
    end else if (cmd_i.invalidate) begin
      pt_waddr = old_q;
    end else begin
      pt_waddr = clr_addr_q;
    end
  end

  fpr_ram #(
    .WIDTH (TW),
    .DEPTH (VIRTUAL_PAGES)
  ) u_page_table (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (page_mod[page_number_i]),
    .rdata_o (pt_rdata)
  );

  fpr_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_FRAMES)
  ) u_frame_owner (
    .clk_i   (clk_i),
    .we_i    (cmd_i.place),
    .waddr_i (frame_q),
    .wdata_i (page_q),
    .re_i    (cmd_i.accept),
    .raddr_i (vp_q),
    .rdata_o (own_rdata)
  );

  // next state of pointers, counters and clear address
  always_comb begin
    n_d         = n_q;
    filled_d    = filled_q;
    vp_d        = vp_q;
    clr_addr_d  = clr_addr_q;
    fault_d     = fault_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;

    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.clr_wr) begin
      clr_addr_d = clr_addr_q + PW'(1);
    end

    if (cmd_i.place) begin
      if (evict_q) begin
        vp_d = ((NW'(vp_q) + NW'(1)) == n_q) ? '0 : vp_q + FW'(1);
      end else begin
        filled_d = filled_q + NW'(1);
      end
    end

    if (cmd_i.load) begin
      acc_d       = (acc_q == '1) ? acc_q : acc_q + COUNT_WIDTH'(1);
      fault_d     = (hit_q || fault_q == '1) ? fault_q : fault_q + COUNT_WIDTH'(1);
      out_valid_d = 1'b1;
    end

    if (cmd_i.restart) begin
      n_d        = n_cfg;
      filled_d   = '0;
      vp_d       = '0;
      clr_addr_d = '0;
      fault_d    = '0;
      acc_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= NW'(RST_N);
      filled_q    <= '0;
      vp_q        <= '0;
      clr_addr_q  <= '0;
      fault_q     <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      n_q         <= n_d;
      filled_q    <= filled_d;
      vp_q        <= vp_d;
      clr_addr_q  <= clr_addr_d;
      fault_q     <= fault_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // access payload: page at accept, lookup outcome at decide
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      page_q <= page_mod[page_number_i];
    end
    if (cmd_i.decide) begin
      hit_q   <= pt_rdata[FW];
      evict_q <= !pt_rdata[FW] && !(filled_q < n_q);
      old_q   <= own_rdata;
      if (pt_rdata[FW]) begin
        frame_q <= pt_rdata[FW-1:0];
      end else if (filled_q < n_q) begin
        frame_q <= FW'(filled_q);
      end else begin
        frame_q <= vp_q;
      end
    end
  end

  // result fields widened then cut to the port widths
  logic [FXW-1:0] frame_ext;
  logic [PXW-1:0] old_ext;
  logic [CXW-1:0] fault_ext;
  logic [CXW-1:0] acc_ext;

  assign frame_ext = FXW'(frame_q);
  assign old_ext   = PXW'(old_q);
  assign fault_ext = CXW'(fault_d);
  assign acc_ext   = CXW'(acc_d);

  // output register, loaded only when free so a stalled result holds
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hit_out_q      <= hit_q;
      frame_out_q    <= frame_ext[fpr_pkg::FRAME_FIELD_W-1:0];
      ev_valid_out_q <= evict_q;
      ev_page_out_q  <= evict_q ? old_ext[fpr_pkg::PAGE_FIELD_W-1:0] : '0;
      fault_out_q    <= fault_ext[fpr_pkg::COUNT_FIELD_W-1:0];
      acc_out_q      <= acc_ext[fpr_pkg::COUNT_FIELD_W-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_out_q;
  assign frame_number_o  = frame_out_q;
  assign evicted_valid_o = ev_valid_out_q;
  assign evicted_page_o  = ev_page_out_q;
  assign fault_total_o   = fault_out_q;
  assign access_total_o  = acc_out_q;

  // fill count never passes the frame count
  `ASSERT_IMPL(a_fill_bound, clk_i, rst_ni, 1'b1, filled_q <= n_q, "fill count above frame count")
  // victim pointer stays inside the active frames
  `ASSERT_IMPL(a_vp_bound, clk_i, rst_ni, 1'b1, NW'(vp_q) < n_q, "victim pointer out of range")
  // round robin only starts once every frame is in use
  `ASSERT_IMPL(a_vp_after_fill, clk_i, rst_ni, vp_q != '0, filled_q == n_q,
               "victim pointer moved before frames filled")
  // a fresh frame is only handed out while one is free
  `ASSERT_IMPL(a_place_room, clk_i, rst_ni, cmd_i.place && !evict_q, filled_q < n_q,
               "frame placed without room")

endmodule

// File: hw/rtl/fpr_ctrl.sv
// controller state machine: clearing pass, access sequencing, output handoff
// depends on fpr_pkg for the command and status types
`timescale 1ns / 1ps

module fpr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  fpr_pkg::status_t status_i,
  output fpr_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_EVICT = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  // config writes are taken in any state
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.restart = cfg_valid_i;

    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.decide = 1'b1;
        priority if (status_i.hit) begin
          state_d = S_DONE;
        end else if (status_i.room) begin
          state_d = S_PLACE;
        end else begin
          state_d = S_EVICT;
        end
      end
      S_EVICT: begin
        cmd_o.invalidate = 1'b1;
        state_d          = S_PLACE;
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase

    // a config write restarts the run with a fresh clearing pass
    if (cfg_valid_i) begin
      state_d = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: dv/tb_fifo_page_replacement_top.sv
// self-checking testbench for fifo_page_replacement_top: directed and random page accesses,
// frame count rewrites and back-pressure, checked against an in-bench predictor
// depends on fpr_pkg and the fifo_page_replacement_top rtl
`timescale 1ns / 1ps

module tb_fifo_page_replacement_top;

  localparam int unsigned CLK_PERIOD     = 8;
  localparam int unsigned PAGES          = fpr_pkg::VIRTUAL_PAGES_DEF;
  localparam int unsigned FRAMES         = fpr_pkg::MAX_FRAMES_DEF;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned END_CYCLES     = 16;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 85;

  typedef logic [fpr_pkg::PAGE_FIELD_W-1:0]  page_t;
  typedef logic [fpr_pkg::FRAME_FIELD_W-1:0] frame_t;
  typedef logic [fpr_pkg::COUNT_FIELD_W-1:0] count_t;
  typedef logic [fpr_pkg::CFG_W-1:0]         frame_cfg_t;

  typedef struct packed {
    logic   hit;
    frame_t frame;
    logic   ev_valid;
    page_t  ev_page;
    count_t faults;
    count_t accesses;
  } page_result_t;

  // dut ports, inputs known from time zero
  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  page_t      page_number_i = '0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic       hit_o;
  frame_t     frame_number_o;
  logic       evicted_valid_o;
  page_t      evicted_page_o;
  count_t     fault_total_o;
  count_t     access_total_o;
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_ready_o;
  frame_cfg_t frame_count_i = '0;

  // predictor state
  frame_cfg_t  frames_setting;
  logic        pt_valid  [PAGES];
  frame_t      pt_frame  [PAGES];
  page_t       frame_page[FRAMES];
  int unsigned victim_slot;
  int unsigned slots_filled;
  count_t      fault_count;
  count_t      access_count;

  page_result_t expected_results[$];

  // bookkeeping
  int unsigned error_count  = 0;
  int unsigned access_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned hits_seen    = 0;
  int unsigned evicts_seen  = 0;
  int unsigned cfg_writes   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned window_base  = 0;
  logic        hold_toggle  = 1'b0;
  logic        hold_seen    = 1'b0;
  int unsigned hold_left    = 0;

  fifo_page_replacement_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .page_number_i  (page_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .frame_number_o (frame_number_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_page_o (evicted_page_o),
    .fault_total_o  (fault_total_o),
    .access_total_o (access_total_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .frame_count_i  (frame_count_i)
  );

  // clock
  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // frames in use after clamping the written count
  function automatic int unsigned active_frames();
    if (frames_setting == 0) return 1;
    if (frames_setting > FRAMES) return FRAMES;
    return 32'(frames_setting);
  endfunction

  // clear the run state, as a frame count write or reset does
  function automatic void restart_run(input frame_cfg_t value);
    frames_setting = value;
    for (int p = 0; p < PAGES; p++) begin
      pt_valid[p] = 1'b0;
      pt_frame[p] = '0;
    end
    for (int f = 0; f < FRAMES; f++) frame_page[f] = '0;
    victim_slot  = 0;
    slots_filled = 0;
    fault_count  = '0;
    access_count = '0;
  endfunction

  // page table lookup with fill-then-round-robin replacement
  function automatic page_result_t predict_access(input page_t page);
    page_result_t r;
    int unsigned  n;
    int unsigned  slot;
    page_t        old;
    n = active_frames();
    r = '0;
    if (access_count != '1) access_count++;
    if (pt_valid[page]) begin
      r.hit   = 1'b1;
      r.frame = pt_frame[page];
    end else begin
      if (fault_count != '1) fault_count++;
      if (slots_filled < n) begin
        slot = slots_filled;
        slots_filled++;
      end else begin
        slot          = victim_slot % n;
        old           = frame_page[slot];
        pt_valid[old] = 1'b0;
        r.ev_valid    = 1'b1;
        r.ev_page     = old;
        victim_slot   = (slot + 1) % n;
      end
      frame_page[slot] = page;
      pt_valid[page]   = 1'b1;
      pt_frame[page]   = frame_t'(slot);
      r.frame          = frame_t'(slot);
    end
    r.faults   = fault_count;
    r.accesses = access_count;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // result checker: a transfer seen settled at the falling edge completes at the next rising edge
  always @(negedge clk_i) begin
    page_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, frame %0d", frame_number_o));
      end else begin
        want = expected_results.pop_front();
        if (hit_o !== want.hit)
          report_mismatch($sformatf("hit %b, want %b", hit_o, want.hit));
        if (frame_number_o !== want.frame)
          report_mismatch($sformatf("frame %0d, want %0d", frame_number_o, want.frame));
        if (evicted_valid_o !== want.ev_valid)
          report_mismatch($sformatf("evicted_valid %b, want %b", evicted_valid_o,
                                    want.ev_valid));
        if (evicted_page_o !== want.ev_page)
          report_mismatch($sformatf("evicted_page %0d, want %0d", evicted_page_o,
                                    want.ev_page));
        if (fault_total_o !== want.faults)
          report_mismatch($sformatf("fault_total %0d, want %0d", fault_total_o, want.faults));
        if (access_total_o !== want.accesses)
          report_mismatch($sformatf("access_total %0d, want %0d", access_total_o,
                                    want.accesses));
        if (want.hit) hits_seen++;
        if (want.ev_valid) evicts_seen++;
      end
    end
  end

  // receiver: long hold-off on request, otherwise random stalls
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(negedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles, %0d results pending",
               $realtime, quiet_cycles, expected_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // one access transfer, with an optional idle gap in front
  task automatic send_page(input page_t page);
    if (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    page_number_i <= page;
    in_valid_i    <= 1'b1;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    expected_results.push_back(predict_access(page));
    access_sent++;
  endtask

  // stop offering and let every expected result come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // frame count write while the block is idle
  task automatic write_frame_count(input frame_cfg_t value);
    drain_results();
    frame_count_i <= value;
    cfg_valid_i   <= 1'b1;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    restart_run(value);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  // random page: mostly a working set a little larger than the frames, some uniform
  function automatic page_t pick_page();
    if ($urandom_range(0, 3) == 0) return page_t'($urandom_range(0, PAGES - 1));
    return page_t'(window_base + $urandom_range(0, active_frames() + 1));
  endfunction

  // reset value of four frames: fill, hits, then round robin eviction, page extremes
  task automatic test_reset_defaults();
    send_page(page_t'(0));
    send_page(page_t'(31));
    send_page(page_t'(0));
    send_page(page_t'(1));
    send_page(page_t'(2));
    send_page(page_t'(3));
    send_page(page_t'(31));
    send_page(page_t'(0));
    send_page(page_t'(31));
    send_page(page_t'(2));
  endtask

  // zero acts as one frame, values past the frame limit act as the limit
  task automatic test_frame_count_clamp();
    write_frame_count(frame_cfg_t'(0));
    send_page(page_t'(5));
    send_page(page_t'(5));
    send_page(page_t'(6));
    send_page(page_t'(5));
    write_frame_count(frame_cfg_t'(63));
    send_page(page_t'(31));
    send_page(page_t'(0));
    send_page(page_t'(17));
    send_page(page_t'(31));
  endtask

  // random traffic over one frame count setting
  task automatic test_random_traffic(input frame_cfg_t value, input int unsigned items);
    write_frame_count(value);
    window_base = $urandom_range(0, PAGES - 1);
    for (int unsigned i = 0; i < items; i++) begin
      if ($urandom_range(0, 15) == 0) window_base = window_base + 1;
      send_page(pick_page());
    end
  endtask

  // receiver holds off while the sender keeps offering, then the sender waits for all results and sends ten more
  task automatic test_backpressure();
    write_frame_count(frame_cfg_t'(8));
    hold_toggle <= ~hold_toggle;
    for (int unsigned i = 0; i < 24; i++) send_page(pick_page());
    drain_results();
    for (int unsigned i = 0; i < 10; i++) send_page(pick_page());
  endtask

  initial begin
    frame_cfg_t settings[8];
    restart_run(frame_cfg_t'(fpr_pkg::FRAME_COUNT_RESET));
    settings = '{frame_cfg_t'(1), frame_cfg_t'(32), frame_cfg_t'(3),
                 frame_cfg_t'($urandom_range(2, 31)), frame_cfg_t'(63), frame_cfg_t'(0),
                 frame_cfg_t'(8), frame_cfg_t'($urandom_range(2, 31))};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sender busy, receiver sparse
    snd_idle_pct = 10;
    rcv_idle_pct = 60;
    test_reset_defaults();
    test_frame_count_clamp();
    for (int k = 0; k < 8; k++) begin
      // sender sparse, receiver busy, then full rate
      if (k == 3) begin
        snd_idle_pct = 60;
        rcv_idle_pct = 10;
      end else if (k == 6) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      test_random_traffic(settings[k], PHASE_ITEMS);
    end
    test_backpressure();

    // final drain and wrap-up
    drain_results();
    repeat (END_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("covered %0d accesses, %0d results, %0d hits, %0d evictions, %0d frame count writes",
             access_sent, results_seen, hits_seen, evicts_seen, cfg_writes);
    $display("incl. clamped frame counts, 1 and 32 frames, random stalls, long back-pressure");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/fpr_pkg.sv
hw/rtl/fpr_ram.sv
hw/rtl/fpr_datapath.sv
hw/rtl/fpr_ctrl.sv
hw/rtl/fifo_page_replacement_top.sv
dv/tb_fifo_page_replacement_top.sv
